// ===== hw/rtl/box_average_downscaler_top_macros.svh =====
// ----------------------------------------------------------------------------
// Box average downscaler assertion macros
// Shared assertion forms used by the downscaler RTL.
// ----------------------------------------------------------------------------
`ifndef BOX_AVERAGE_DOWNSCALER_TOP_MACROS_SVH
`define BOX_AVERAGE_DOWNSCALER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BAD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bad_pkg.sv =====
// ----------------------------------------------------------------------------
// Box average downscaler package
// Widths, register indexes and shared types of the downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bad_pkg;

  localparam int SIZE_W         = 13;
  localparam int PIX_W          = 8;
  localparam int SUM_W          = 32;
  localparam int CNT_W          = 2 * SIZE_W;
  localparam int CFG_IDX_W      = 3;
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

  // Status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bad_div.sv =====
// ----------------------------------------------------------------------------
// Box average downscaler divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bad_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [bad_pkg::SUM_W-1:0]  dividend,
  input  wire logic [bad_pkg::CNT_W-1:0]  divisor,
  output bad_pkg::div_stat_t              stat,
  output logic      [bad_pkg::SUM_W-1:0]  quotient
);
  import bad_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r, done_r;
  logic [CNT_W:0]    trial;

  always_comb begin
    trial   = {rem_r[CNT_W-1:0], quo_r[SUM_W-1]};
    quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt    = trial - {1'b0, dvs_r};
      quo_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W);
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        quo_r  <= quo_nxt;
        rem_r  <= rem_nxt;
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bad_sum_ram.sv =====
// ----------------------------------------------------------------------------
// Box average downscaler column sum memory
// Single-port RAM of per-column RGB sums with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bad_sum_ram #(
  parameter int DEPTH = bad_pkg::DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               addr,
  input  wire logic [3*bad_pkg::SUM_W-1:0] wr_data,
  output logic      [3*bad_pkg::SUM_W-1:0] rd_data
);
  import bad_pkg::*;

  logic [3*SUM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/box_average_downscaler_top.sv =====
// ----------------------------------------------------------------------------
// Box average downscaler
// Area-average RGB downscaler with per-column sums held in a RAM.
// ----------------------------------------------------------------------------
//  Channel   Ports                         Direction  Moves
//  in        in_valid/in_ready             sink       one source pixel
//  out       out_valid/out_ready           source     one block mean
//  cfg       cfg_valid/cfg_ready           sink       one register write
//
//  A pixel that does not close a block passes through accept, RAM read and
//  write back, and position update; a new column or row bound adds a
//  divider pass. A closing pixel adds three mean divisions and an emit
//  step. Reset loads the default bounds directly; a register write
//  costs two divider passes before the next pixel is taken.
//  A waiting result holds the block only at the next closing pixel.
`default_nettype none

module box_average_downscaler_top #(
  parameter int MAX_WIDTH  = bad_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bad_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [bad_pkg::PIX_W-1:0]       in_red_in,
  input  wire logic [bad_pkg::PIX_W-1:0]       in_green_in,
  input  wire logic [bad_pkg::PIX_W-1:0]       in_blue_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [bad_pkg::PIX_W-1:0]       out_red_out,
  output logic      [bad_pkg::PIX_W-1:0]       out_green_out,
  output logic      [bad_pkg::PIX_W-1:0]       out_blue_out,
  output logic                                 out_row_end,
  output logic                                 out_frame_end,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bad_pkg::SIZE_W-1:0]      cfg_data
);
  import bad_pkg::*;

  `include "box_average_downscaler_top_macros.svh"

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int EXT  = SIZE_W + 1;
  localparam int PROD = EXT + SIZE_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_MEAN, ST_START, ST_DIV, ST_EMIT, ST_ADV
  } state_t;

  typedef enum logic [2:0] {
    T_MEAN, T_CB0, T_RB0, T_CB, T_RB
  } div_tgt_t;

  state_t   state_r;
  div_tgt_t tgt_r;

  logic [SIZE_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [SIZE_W-1:0] eff_sw, eff_sh, eff_dw, eff_dh;
  logic [SIZE_W-1:0] sc_r, sr_r, tc_r, tr_r, cb_r, rb_r, bcs_r, brs_r;
  logic [SIZE_W-1:0] cb0_r, rb0_r;
  logic              init_pend_r;
  logic [PIX_W-1:0]  pix_r [3];
  logic [SUM_W-1:0]  sum_r [3];
  logic [1:0]        ch_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PIX_W-1:0]  mean_r [3];
  logic              row_end_r, frame_end_r;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_red_r, out_green_r, out_blue_r;
  logic              out_row_end_r, out_frame_end_r;

  logic [SUM_W-1:0]  div_a_r;
  logic [CNT_W-1:0]  div_b_r;
  logic              div_start;
  div_stat_t         div_stat;
  logic [SUM_W-1:0]  div_q;

  logic                ram_rd, ram_wr;
  logic [3*SUM_W-1:0]  ram_q, ram_wdata;
  logic [SUM_W-1:0]    new_sum [3];
  logic                first_px, close_blk;

  logic              in_acc, cfg_acc;

  // Position update results.
  logic [SIZE_W-1:0] sc_nxt, sr_nxt, tc_nxt, tr_nxt, bcs_nxt, brs_nxt, cb_nxt, rb_nxt;
  logic              adv_div;
  div_tgt_t          adv_tgt;
  logic [PROD-1:0]   adv_prod;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, logic [EXT-1:0] hi);
    logic [SIZE_W-1:0] res;
    begin
      res = v;
      if (v == '0) begin
        res = SIZE_W'(1);
      end else if ({1'b0, v} > hi) begin
        res = hi[SIZE_W-1:0];
      end
      return res;
    end
  endfunction

  assign eff_sw = clamp_size(src_w_r, EXT'(MAX_WIDTH));
  assign eff_sh = clamp_size(src_h_r, EXT'(MAX_HEIGHT));
  assign eff_dw = clamp_size(dst_w_r, {1'b0, eff_sw});
  assign eff_dh = clamp_size(dst_h_r, {1'b0, eff_sh});

  assign cfg_ready = rst_n && (state_r == ST_IDLE);
  assign in_ready  = rst_n && (state_r == ST_IDLE) && !init_pend_r && !cfg_valid;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = in_valid && in_ready;

  assign ram_rd    = in_acc;
  assign ram_wr    = (state_r == ST_RD);
  assign div_start = (state_r == ST_START);

  assign first_px  = (sc_r == bcs_r) && (sr_r == brs_r);
  assign close_blk = ({1'b0, sc_r} + 1'b1 == {1'b0, cb_r}) &&
                     ({1'b0, sr_r} + 1'b1 == {1'b0, rb_r});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (first_px) begin
        new_sum[i] = SUM_W'(pix_r[i]);
      end else begin
        new_sum[i] = ram_q[(2-i)*SUM_W +: SUM_W] + SUM_W'(pix_r[i]);
      end
    end
    ram_wdata = {new_sum[0], new_sum[1], new_sum[2]};
  end

  always_comb begin
    logic [EXT-1:0] sc_inc, sr_inc, tc_inc, tr_inc, idx1;
    logic [SIZE_W-1:0] mul_s;
    begin
      sc_inc  = {1'b0, sc_r} + 1'b1;
      sr_inc  = {1'b0, sr_r} + 1'b1;
      tc_inc  = {1'b0, tc_r} + 1'b1;
      tr_inc  = {1'b0, tr_r} + 1'b1;
      sc_nxt  = sc_r;
      sr_nxt  = sr_r;
      tc_nxt  = tc_r;
      tr_nxt  = tr_r;
      bcs_nxt = bcs_r;
      brs_nxt = brs_r;
      cb_nxt  = cb_r;
      rb_nxt  = rb_r;
      adv_div = 1'b0;
      adv_tgt = T_CB;
      idx1    = '0;
      mul_s   = eff_sw;
      if (sc_inc >= {1'b0, eff_sw}) begin
        // Source row done: columns restart, rows may close a band.
        sc_nxt  = '0;
        tc_nxt  = '0;
        bcs_nxt = '0;
        cb_nxt  = cb0_r;
        sr_nxt  = sr_inc[SIZE_W-1:0];
        if (sr_inc >= {1'b0, rb_r}) begin
          if (tr_inc >= {1'b0, eff_dh} || sr_inc >= {1'b0, eff_sh}) begin
            tr_nxt  = '0;
            sr_nxt  = '0;
            brs_nxt = '0;
            rb_nxt  = rb0_r;
          end else begin
            tr_nxt  = tr_inc[SIZE_W-1:0];
            brs_nxt = rb_r;
            adv_div = 1'b1;
            adv_tgt = T_RB;
            idx1    = tr_inc + 1'b1;
            mul_s   = eff_sh;
          end
        end
      end else begin
        sc_nxt = sc_inc[SIZE_W-1:0];
        if (sc_inc >= {1'b0, cb_r}) begin
          if (tc_inc >= {1'b0, eff_dw}) begin
            tc_nxt  = '0;
            bcs_nxt = '0;
            cb_nxt  = cb0_r;
          end else begin
            tc_nxt  = tc_inc[SIZE_W-1:0];
            bcs_nxt = cb_r;
            adv_div = 1'b1;
            adv_tgt = T_CB;
            idx1    = tc_inc + 1'b1;
          end
        end
      end
      adv_prod = PROD'(idx1) * PROD'(mul_s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tgt_r       <= T_MEAN;
      src_w_r     <= SIZE_W'(1);
      src_h_r     <= SIZE_W'(1);
      dst_w_r     <= SIZE_W'(1);
      dst_h_r     <= SIZE_W'(1);
      sc_r        <= '0;
      sr_r        <= '0;
      tc_r        <= '0;
      tr_r        <= '0;
      bcs_r       <= '0;
      brs_r       <= '0;
      cb_r        <= SIZE_W'(1);
      rb_r        <= SIZE_W'(1);
      cb0_r       <= SIZE_W'(1);
      rb0_r       <= SIZE_W'(1);
      init_pend_r <= 1'b0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (cfg_acc) begin
            if (cfg_index == REG_SRC_WIDTH || cfg_index == REG_SRC_HEIGHT ||
                cfg_index == REG_DST_WIDTH || cfg_index == REG_DST_HEIGHT) begin
              case (cfg_index)
                REG_SRC_WIDTH:  src_w_r <= cfg_data;
                REG_SRC_HEIGHT: src_h_r <= cfg_data;
                REG_DST_WIDTH:  dst_w_r <= cfg_data;
                REG_DST_HEIGHT: dst_h_r <= cfg_data;
                default: ;
              endcase
              sc_r        <= '0;
              sr_r        <= '0;
              tc_r        <= '0;
              tr_r        <= '0;
              bcs_r       <= '0;
              brs_r       <= '0;
              init_pend_r <= 1'b1;
            end
          end else if (init_pend_r) begin
            div_a_r <= SUM_W'(eff_sw);
            div_b_r <= CNT_W'(eff_dw);
            tgt_r   <= T_CB0;
            state_r <= ST_START;
          end else if (in_acc) begin
            pix_r[0] <= in_red_in;
            pix_r[1] <= in_green_in;
            pix_r[2] <= in_blue_in;
            state_r  <= ST_RD;
          end
        end
        ST_RD: begin
          for (int i = 0; i < 3; i++) begin
            sum_r[i] <= new_sum[i];
          end
          if (close_blk) begin
            cnt_r       <= CNT_W'((cb_r - bcs_r) * (rb_r - brs_r));
            row_end_r   <= ({1'b0, tc_r} + 1'b1 == {1'b0, eff_dw});
            frame_end_r <= ({1'b0, tc_r} + 1'b1 == {1'b0, eff_dw}) &&
                           ({1'b0, tr_r} + 1'b1 == {1'b0, eff_dh});
            ch_r        <= '0;
            state_r     <= ST_MEAN;
          end else begin
            state_r <= ST_ADV;
          end
        end
        ST_MEAN: begin
          div_a_r <= sum_r[ch_r];
          div_b_r <= (cnt_r == '0) ? CNT_W'(1) : cnt_r;
          tgt_r   <= T_MEAN;
          state_r <= ST_START;
        end
        ST_START: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            case (tgt_r)
              T_MEAN: begin
                mean_r[ch_r] <= div_q[PIX_W-1:0];
                if (ch_r == 2'd2) begin
                  state_r <= ST_EMIT;
                end else begin
                  ch_r    <= ch_r + 1'b1;
                  state_r <= ST_MEAN;
                end
              end
              T_CB0: begin
                cb0_r   <= div_q[SIZE_W-1:0];
                cb_r    <= div_q[SIZE_W-1:0];
                div_a_r <= SUM_W'(eff_sh);
                div_b_r <= CNT_W'(eff_dh);
                tgt_r   <= T_RB0;
                state_r <= ST_START;
              end
              T_RB0: begin
                rb0_r       <= div_q[SIZE_W-1:0];
                rb_r        <= div_q[SIZE_W-1:0];
                init_pend_r <= 1'b0;
                state_r     <= ST_IDLE;
              end
              T_CB: begin
                cb_r    <= div_q[SIZE_W-1:0];
                state_r <= ST_IDLE;
              end
              T_RB: begin
                rb_r    <= div_q[SIZE_W-1:0];
                state_r <= ST_IDLE;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r     <= 1'b1;
            out_red_r       <= mean_r[0];
            out_green_r     <= mean_r[1];
            out_blue_r      <= mean_r[2];
            out_row_end_r   <= row_end_r;
            out_frame_end_r <= frame_end_r;
            state_r         <= ST_ADV;
          end
        end
        ST_ADV: begin
          sc_r  <= sc_nxt;
          sr_r  <= sr_nxt;
          tc_r  <= tc_nxt;
          tr_r  <= tr_nxt;
          bcs_r <= bcs_nxt;
          brs_r <= brs_nxt;
          cb_r  <= cb_nxt;
          rb_r  <= rb_nxt;
          if (adv_div) begin
            div_a_r <= SUM_W'(adv_prod);
            div_b_r <= CNT_W'(adv_tgt == T_RB ? eff_dh : eff_dw);
            tgt_r   <= adv_tgt;
            state_r <= ST_START;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  bad_sum_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_sum_ram (
    .clk     (clk),
    .rd_en   (ram_rd),
    .wr_en   (ram_wr),
    .addr    (tc_r[AW-1:0]),
    .wr_data (ram_wdata),
    .rd_data (ram_q)
  );

  bad_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_red_r;
  assign out_green_out = out_green_r;
  assign out_blue_out  = out_blue_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

  `BAD_ASSERT_NEXT(a_acc_to_rd, in_valid && in_ready, state_r == ST_RD,
    "accepted pixel did not reach the RAM read stage")
  `BAD_ASSERT_SAME(a_pos_in_block, state_r == ST_IDLE && !init_pend_r,
    sc_r < cb_r && sr_r < rb_r, "source position outside the current block")
  `BAD_ASSERT_SAME(a_col_in_range, state_r == ST_IDLE && !init_pend_r,
    tc_r < eff_dw, "destination column beyond destination width")
  `BAD_ASSERT_SAME(a_div_free, div_start, !div_stat.busy,
    "divider started while busy")

endmodule

`default_nettype wire
